// ----- design/cscb_pkg.sv -----
package cscb_pkg;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int PROD_W  = 3;
   localparam int COORD_W = 22;
   localparam int ZOOM_W  = 5;
   localparam int CNT_W   = 16;
   localparam int PCNT_W  = 4;
   localparam int KEY_W   = 2 * COORD_W + ZOOM_W;

   // Parameter defaults
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int MAX_PRODUCERS_DEF = 8;

   // Producer count after reset
   localparam logic [PCNT_W-1:0] PCOUNT_RESET = PCNT_W'(1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PROCESSED = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READY     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Controller to datapath
   typedef struct packed {
      logic start;       // request transfer taken, capture fields
      logic scan_issue;  // read the entry at the scan index
      logic commit;      // update the table and load the result register
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;   // scan index is at the last entry
      logic rsp_free;    // result register can take a new result
   } dp_status_type;

endpackage

// ----- design/completion_scoreboard_top.sv -----
// A request transfer starts a scan of every table entry; after the last compare the item
//   commits once the result register is free. A new request is taken only after the commit;
//   the single table read port scans every entry once per item, one per cycle.
// A waiting result does not block the next item's scan, only its commit.
// Reset (synchronous, active high) clears all valid bits and the controller at once,
//   sets producer_count to 1; table memory contents are left as they are.
module completion_scoreboard_top
   import cscb_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [PROD_W-1:0]   req_producer,
   input  logic [COORD_W-1:0]  req_tile_x,
   input  logic [COORD_W-1:0]  req_tile_y,
   input  logic [ZOOM_W-1:0]   req_zoom_level,
   input  logic [CNT_W-1:0]    req_item_count,
   input  logic                csr_wr_en,
   input  logic [PCNT_W-1:0]   csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tile_ready,
   output logic [COORD_W-1:0]  rsp_ready_x,
   output logic [COORD_W-1:0]  rsp_ready_y,
   output logic [ZOOM_W-1:0]   rsp_ready_zoom,
   output logic                rsp_table_full
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   cscb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cscb_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_PRODUCERS (MAX_PRODUCERS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_command),
      .req_producer   (req_producer),
      .req_tile_x     (req_tile_x),
      .req_tile_y     (req_tile_y),
      .req_zoom_level (req_zoom_level),
      .req_item_count (req_item_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_ready (rsp_tile_ready),
      .rsp_ready_x    (rsp_ready_x),
      .rsp_ready_y    (rsp_ready_y),
      .rsp_ready_zoom (rsp_ready_zoom),
      .rsp_table_full (rsp_table_full)
   );

endmodule

// ----- design/cscb_ctrl.sv -----
module cscb_ctrl
   import cscb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output ctl_cmd_type   cmd,
   input  dp_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.start      = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         // last read is compared here
         ST_WAIT: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // A scan always runs to its end before the commit
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && !status.scan_last |=> state_ff == ST_SCAN)
      else $error("scan left early");

   // Commit only happens with room for the result
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.rsp_free)
      else $error("commit without free result register");

   // A new request follows only a finished one
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> $past(state_ff) == ST_COMMIT || $past(state_ff) == ST_IDLE)
      else $error("start in the middle of an item");

endmodule

// ----- design/cscb_datapath.sv -----
module cscb_datapath
   import cscb_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_PRODUCERS = MAX_PRODUCERS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_status_type       status,
   // request fields
   input  logic [CMD_W-1:0]    req_command,
   input  logic [PROD_W-1:0]   req_producer,
   input  logic [COORD_W-1:0]  req_tile_x,
   input  logic [COORD_W-1:0]  req_tile_y,
   input  logic [ZOOM_W-1:0]   req_zoom_level,
   input  logic [CNT_W-1:0]    req_item_count,
   // producer count register
   input  logic                csr_wr_en,
   input  logic [PCNT_W-1:0]   csr_wr_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tile_ready,
   output logic [COORD_W-1:0]  rsp_ready_x,
   output logic [COORD_W-1:0]  rsp_ready_y,
   output logic [ZOOM_W-1:0]   rsp_ready_zoom,
   output logic                rsp_table_full
);

   localparam int IW    = $clog2(TABLE_ENTRIES);
   localparam int MW    = MAX_PRODUCERS;
   localparam int ROW_W = KEY_W + MW + CNT_W;

   // Table: key, mask and pending count in memory, valid bits in flops
   logic [ROW_W-1:0]         mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;

   logic [PCNT_W-1:0]  pcount_ff;

   // Captured request
   logic [CMD_W-1:0]   cmd_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [ZOOM_W-1:0]  z_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [KEY_W-1:0]   key;

   // Scan pipeline
   logic [IW-1:0]      scan_idx_ff;
   logic [ROW_W-1:0]   rd_row_ff;
   logic               rd_valid_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               rd_live_ff;
   logic               hit_ff;
   logic [IW-1:0]      hit_idx_ff;
   logic [MW-1:0]      hit_mask_ff;
   logic [CNT_W-1:0]   hit_pend_ff;
   logic               free_found_ff;
   logic [IW-1:0]      free_idx_ff;
   logic [KEY_W-1:0]   rd_key;
   logic [MW-1:0]      rd_mask;
   logic [CNT_W-1:0]   rd_pend;

   // Commit logic
   logic [MW-1:0]      full_mask;
   logic [MW-1:0]      prod_bit;
   logic [CNT_W:0]     pend_sum;
   logic [CNT_W-1:0]   new_pend;
   logic [MW-1:0]      new_mask;
   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   logic [ROW_W-1:0]   wr_row;
   logic               set_en;
   logic               clr_en;
   logic               ready;
   logic               tfull;

   // Result register
   logic               rsp_valid_ff;
   logic               rsp_ready_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [ZOOM_W-1:0]  rsp_z_ff;
   logic               rsp_full_ff;

   // Producer count register
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= PCOUNT_RESET;
      end else if (csr_wr_en) begin
         pcount_ff <= csr_wr_data;
      end
   end

   // Capture request on transfer
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff   <= req_command;
         prod_ff  <= req_producer;
         x_ff     <= req_tile_x;
         y_ff     <= req_tile_y;
         z_ff     <= req_zoom_level;
         count_ff <= req_item_count;
      end
   end

   assign key = {z_ff, y_ff, x_ff};

   // Scan read stage, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + IW'(1);
         end
         rd_live_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_row_ff   <= mem[scan_idx_ff];
         rd_valid_ff <= valid_ff[scan_idx_ff];
         rd_idx_ff   <= scan_idx_ff;
      end
      if (wr_en) begin
         mem[wr_idx] <= wr_row;
      end
   end

   assign rd_key  = rd_row_ff[ROW_W-1 -: KEY_W];
   assign rd_mask = rd_row_ff[CNT_W +: MW];
   assign rd_pend = rd_row_ff[CNT_W-1:0];

   // Compare stage: key match and first free entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_live_ff) begin
         if (rd_valid_ff && rd_key == key) begin
            hit_ff <= 1'b1;
         end
         if (!rd_valid_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_live_ff && rd_valid_ff && rd_key == key) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_mask_ff <= rd_mask;
         hit_pend_ff <= rd_pend;
      end
      if (rd_live_ff && !rd_valid_ff && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // Full mask from producer count, clamped to 1 .. MAX_PRODUCERS
   always_comb begin
      for (int j = 0; j < MW; j++) begin
         full_mask[j] = (j == 0) || (32'(j) < 32'(pcount_ff));
         prod_bit[j]  = full_mask[j] && (32'(j) == 32'(prod_ff));
      end
   end

   assign pend_sum = {1'b0, hit_pend_ff} + {1'b0, count_ff};

   // Table update and result
   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = hit_idx_ff;
      new_mask = hit_mask_ff;
      new_pend = hit_pend_ff;
      set_en   = 1'b0;
      clr_en   = 1'b0;
      ready    = 1'b0;
      tfull    = 1'b0;
      case (cmd_ff)
         CMD_PROCESSED: begin
            if (hit_ff) begin
               new_pend = pend_sum[CNT_W] ? COUNT_MAX : pend_sum[CNT_W-1:0];
               new_mask = hit_mask_ff | prod_bit;
               wr_en    = 1'b1;
               if (new_mask == full_mask && new_pend == '0) begin
                  clr_en = 1'b1;
                  ready  = 1'b1;
               end
            end else if (prod_bit == full_mask && count_ff == '0) begin
               ready = 1'b1;
            end else if (free_found_ff) begin
               wr_idx   = free_idx_ff;
               new_mask = prod_bit;
               new_pend = count_ff;
               wr_en    = 1'b1;
               set_en   = 1'b1;
            end else begin
               tfull = 1'b1;
            end
         end
         CMD_READY: begin
            if (hit_ff) begin
               new_pend = (count_ff >= hit_pend_ff) ? '0 : hit_pend_ff - count_ff;
               wr_en    = 1'b1;
               if (new_pend == '0 && hit_mask_ff == full_mask) begin
                  clr_en = 1'b1;
                  ready  = 1'b1;
               end
            end
         end
         CMD_REMOVE: begin
            clr_en = hit_ff;
         end
         default: begin
            // unused command: no effect, all-zero result
         end
      endcase
      wr_en  = wr_en && cmd.commit;
      wr_row = {key, new_mask, new_pend};
   end

   // Valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && set_en) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (cmd.commit && clr_en) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ready_ff <= ready;
         rsp_x_ff     <= ready ? x_ff : '0;
         rsp_y_ff     <= ready ? y_ff : '0;
         rsp_z_ff     <= ready ? z_ff : '0;
         rsp_full_ff  <= tfull;
      end
   end

   assign status.scan_last = (scan_idx_ff == IW'(TABLE_ENTRIES - 1));
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_ready = rsp_ready_ff;
   assign rsp_ready_x    = rsp_x_ff;
   assign rsp_ready_y    = rsp_y_ff;
   assign rsp_ready_zoom = rsp_z_ff;
   assign rsp_table_full = rsp_full_ff;

   // A matched entry is still live when it is updated
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && hit_ff |-> valid_ff[hit_idx_ff])
      else $error("commit on a stale entry");

   // A new entry only goes into a free slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && set_en |-> !valid_ff[free_idx_ff])
      else $error("allocation over a live entry");

   // Every commit puts a result in the register
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result lost at commit");

   // A result never reports both ready and full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ready_ff && rsp_full_ff))
      else $error("ready and full in one result");

endmodule
